### hw/rtl/ssrb_pkg.sv
package ssrb_pkg;

    // buffer depths, one slot of each stays empty
    localparam int RX_DEPTH = 128;
    localparam int TX_DEPTH = 2048;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    // occupancy counters, wide enough to hold the depth itself
    localparam int RX_CW = RX_AW + 1;
    localparam int TX_CW = TX_AW + 1;

    // fixed field widths of the stream payload
    localparam int FUNC_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int RX_COUNT_W = 7;
    localparam int TX_FREE_W  = 11;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FN_LINE_RX  = 3'd0,
        FN_TX_EMPTY = 3'd1,
        FN_PUT      = 3'd2,
        FN_GET      = 3'd3,
        FN_FLUSH_RX = 3'd4,
        FN_FLUSH_TX = 3'd5,
        FN_STATUS   = 3'd6
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                  sending;
        logic [TX_FREE_W-1:0]  tx_free;
        logic [RX_COUNT_W-1:0] rx_count;
        logic                  rx_dropped;
        logic                  put_accepted;
        logic [BYTE_W-1:0]     read_byte;
        logic                  read_valid;
        logic [BYTE_W-1:0]     tx_byte;
        logic                  tx_valid;
    } t_result;

endpackage

### hw/rtl/ssrb_ram.sv
module ssrb_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/serial_tx_rx_ring_buffers_core.sv
// serial transmit / receive ring buffers
//
// slave channel (i_s_*) carries one request: a function code and a byte.
// functions: line byte received, transmit empty, put, get, flush rx,
// flush tx, status. every request gives exactly one result on the master
// channel (o_m_*): transmit hand-off, get data, put status, drop flag,
// receive occupancy, transmit free space and the busy flag.
//
// each request is accepted in the idle state and then executed: the
// accept cycle reads both buffer rams at their read pointers, the execute
// state uses the registered ram data, writes back at most one entry per
// buffer and loads the result register. no new request is taken until the
// last one commits; o_m_tvalid rises when the result register is loaded.
//
// reset clears the state, the four pointers, the busy and valid flags;
// ram contents are left as they are, entries are only read after being written.
// when the receiver stalls, the result register holds its result and one
// more request is taken; its result waits until the register is freed.
module serial_tx_rx_ring_buffers_core
    import ssrb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [2:0] func, [10:3] data, [15:11] zero
    input  logic [S_DATA_W-1:0] i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] read_valid, [17:10] read_byte,
    // [18] put_accepted, [19] rx_dropped, [26:20] rx_count,
    // [37:27] tx_free, [38] sending, [39] zero
    output logic [M_DATA_W-1:0] o_m_tdata
);

    t_state r_state, n_state;

    // request held during execution
    t_func             r_func;
    logic [BYTE_W-1:0] r_data;

    // ring pointers and transmitter busy flag
    logic [RX_AW-1:0] r_rx_wr, r_rx_rd, n_rx_wr, n_rx_rd;
    logic [TX_AW-1:0] r_tx_wr, r_tx_rd, n_tx_wr, n_tx_rd;
    logic             r_busy, n_busy;

    // result register
    logic    r_m_valid;
    t_result r_res, n_res;

    logic              s_accept;
    logic              commit;
    logic              rx_we, tx_we;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    logic [RX_AW-1:0] rx_wr_inc, rx_rd_inc;
    logic [TX_AW-1:0] tx_wr_inc, tx_rd_inc;
    logic             rx_full, rx_empty, tx_full, tx_empty;
    logic [RX_CW-1:0] rx_occ;
    logic [TX_CW-1:0] tx_occ, tx_space;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    // result register free or being emptied this cycle
    assign commit     = (r_state == ST_EXEC) && (!r_m_valid || i_m_tready);

    // both rams are read every cycle at the current read pointers; the
    // pointers only move at commit, so data read in the accept cycle stays
    // valid through a stalled execute cycle
    ssrb_ram #(.DEPTH(RX_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (r_data),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_rdata)
    );

    ssrb_ram #(.DEPTH(TX_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (r_data),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_rdata)
    );

    // wrap-around increments for any depth
    assign rx_wr_inc = (r_rx_wr == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_wr + 1'b1;
    assign rx_rd_inc = (r_rx_rd == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_rd + 1'b1;
    assign tx_wr_inc = (r_tx_wr == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_wr + 1'b1;
    assign tx_rd_inc = (r_tx_rd == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_rd + 1'b1;

    assign rx_full  = (rx_wr_inc == r_rx_rd);
    assign rx_empty = (r_rx_wr == r_rx_rd);
    assign tx_full  = (tx_wr_inc == r_tx_rd);
    assign tx_empty = (r_tx_wr == r_tx_rd);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func <= t_func'(i_s_tdata[FUNC_W-1:0]);
            r_data <= i_s_tdata[FUNC_W +: BYTE_W];
        end
    end

    // execute: read-modify-write of pointers and at most one entry per ram
    always_comb begin
        n_rx_wr = r_rx_wr;
        n_rx_rd = r_rx_rd;
        n_tx_wr = r_tx_wr;
        n_tx_rd = r_tx_rd;
        n_busy  = r_busy;
        rx_we   = 1'b0;
        tx_we   = 1'b0;
        n_res   = '0;
        case (r_func)
            FN_LINE_RX: begin
                if (!rx_full) begin
                    rx_we   = commit;
                    n_rx_wr = rx_wr_inc;
                end else begin
                    n_res.rx_dropped = 1'b1;
                end
            end
            FN_TX_EMPTY: begin
                if (!tx_empty) begin
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = tx_rdata;
                    n_tx_rd        = tx_rd_inc;
                    n_busy         = 1'b1;
                end else begin
                    n_busy = 1'b0;
                end
            end
            FN_PUT: begin
                if (!tx_full) begin
                    tx_we              = commit;
                    n_tx_wr            = tx_wr_inc;
                    n_res.put_accepted = 1'b1;
                    if (!r_busy) begin
                        // empty buffer: the byte just queued goes straight out
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = tx_empty ? r_data : tx_rdata;
                        n_tx_rd        = tx_rd_inc;
                        n_busy         = 1'b1;
                    end
                end
            end
            FN_GET: begin
                if (!rx_empty) begin
                    n_res.read_valid = 1'b1;
                    n_res.read_byte  = rx_rdata;
                    n_rx_rd          = rx_rd_inc;
                end
            end
            FN_FLUSH_RX: begin
                n_rx_wr = r_rx_rd;
            end
            FN_FLUSH_TX: begin
                n_tx_wr = r_tx_rd;
                n_busy  = 1'b0;
            end
            default: begin
                // status and the unused code change nothing
            end
        endcase

        // levels after this request
        if (n_rx_wr >= n_rx_rd) begin
            rx_occ = RX_CW'(n_rx_wr) - RX_CW'(n_rx_rd);
        end else begin
            rx_occ = RX_CW'(n_rx_wr) + RX_CW'(RX_DEPTH) - RX_CW'(n_rx_rd);
        end
        if (n_tx_wr >= n_tx_rd) begin
            tx_occ = TX_CW'(n_tx_wr) - TX_CW'(n_tx_rd);
        end else begin
            tx_occ = TX_CW'(n_tx_wr) + TX_CW'(TX_DEPTH) - TX_CW'(n_tx_rd);
        end
        tx_space       = TX_CW'(TX_DEPTH - 1) - tx_occ;
        n_res.rx_count = RX_COUNT_W'(rx_occ);
        n_res.tx_free  = TX_FREE_W'(tx_space);
        n_res.sending  = n_busy;
    end

    // pointers and busy flag move only at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr <= '0;
            r_rx_rd <= '0;
            r_tx_wr <= '0;
            r_tx_rd <= '0;
            r_busy  <= 1'b0;
        end else if (commit) begin
            r_rx_wr <= n_rx_wr;
            r_rx_rd <= n_rx_rd;
            r_tx_wr <= n_tx_wr;
            r_tx_rd <= n_tx_rd;
            r_busy  <= n_busy;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (commit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_res};

endmodule
